FILE: rtl/core/free_run_gap_classifier_defines.svh
// assertion macros for the free run gap classifier
`ifndef FREE_RUN_GAP_CLASSIFIER_DEFINES_SVH
`define FREE_RUN_GAP_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define FGC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define FGC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define FGC_ASSERT(lbl, clk, rst, prop)
`define FGC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: rtl/core/fgc_pkg.sv
// shared types and constants for the free run gap classifier
`default_nettype none

package fgc_pkg;

   localparam int unsigned LINE_LENGTH = 4096;
   localparam int unsigned COL_W       = 12;
   localparam int unsigned FREE_W      = 13;
   localparam int unsigned UNK_W       = 8;
   localparam int unsigned FIN_W       = 13;

   localparam logic [FREE_W-1:0] FREE_MAX    = '1;

   localparam logic [1:0] CELL_FREE     = 2'd0;
   localparam logic [1:0] CELL_OCCUPIED = 2'd1;
   localparam logic [1:0] CELL_UNKNOWN  = 2'd2;

   localparam logic CSR_MIN_RUN_LENGTH    = 1'b0;
   localparam logic CSR_UNKNOWN_TOLERANCE = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_GAP    = 2'd0,
      VERDICT_NARROW = 2'd1,
      VERDICT_SHORT  = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [11:0]      min_run_length;
      logic [UNK_W-1:0] unknown_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]  run_start;
      logic [FREE_W-1:0] free_count;
      logic [UNK_W-1:0]  unknown_count;
   } run_state_type;

   typedef struct packed {
      logic [1:0]       cell_class;
      logic             in_bounds;
      logic [COL_W-1:0] column;
      logic             line_end;
   } cell_type;

   typedef struct packed {
      logic              emit;
      verdict_type       verdict;
      logic [COL_W-1:0]  run_begin;
      logic [FIN_W-1:0]  run_finish;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/fgc_step.sv
// per-cell run tracking: next run state and optional report
`default_nettype none

module fgc_step #(
   parameter int unsigned LINE_LENGTH = fgc_pkg::LINE_LENGTH
) (
   input  wire fgc_pkg::cfg_type       cfg,
   input  wire fgc_pkg::run_state_type cur,
   input  wire fgc_pkg::cell_type      cur_cell,
   output fgc_pkg::run_state_type      nxt,
   output fgc_pkg::result_type         res
);

   localparam logic [16:0] LAST_COLUMN = 17'(LINE_LENGTH - 1);

   logic               last_cell;
   logic               run_open;
   logic signed [13:0] close_fin;
   logic signed [13:0] span;
   logic               wide;

   assign last_cell = cur_cell.line_end || ({5'b0, cur_cell.column} >= LAST_COLUMN);
   assign run_open  = (cur.free_count != '0);

   // run ends just before this cell, minus trailing unknowns
   assign close_fin = $signed({2'b0, cur_cell.column}) - 14'sd1
                      - $signed({6'b0, cur.unknown_count});
   assign span      = close_fin - $signed({2'b0, cur.run_start});
   assign wide      = (span >= $signed({2'b0, cfg.min_run_length}));

   always_comb begin
      nxt            = cur;
      res.emit       = 1'b0;
      res.verdict    = fgc_pkg::VERDICT_GAP;
      res.run_begin  = cur.run_start;
      res.run_finish = close_fin[fgc_pkg::FIN_W-1:0];
      if (!cur_cell.in_bounds) begin
         if (run_open && (cur.free_count < {1'b0, cfg.min_run_length})) begin
            res.emit       = 1'b1;
            res.verdict    = fgc_pkg::VERDICT_SHORT;
            res.run_finish = {1'b0, cur_cell.column} - 13'd1;
         end
         nxt.free_count    = '0;
         nxt.unknown_count = '0;
      end else if ((cur_cell.cell_class == fgc_pkg::CELL_FREE) && !last_cell) begin
         if (!run_open) begin
            nxt.run_start = cur_cell.column;
         end
         if (cur.free_count != fgc_pkg::FREE_MAX) begin
            nxt.free_count = cur.free_count + 13'd1;
         end
         nxt.unknown_count = '0;
      end else if ((cur_cell.cell_class == fgc_pkg::CELL_UNKNOWN)
                   && (cur.unknown_count < cfg.unknown_tolerance)
                   && run_open && !last_cell) begin
         nxt.unknown_count = cur.unknown_count + 8'd1;
      end else if (run_open) begin
         res.emit          = 1'b1;
         res.verdict       = wide ? fgc_pkg::VERDICT_GAP : fgc_pkg::VERDICT_NARROW;
         nxt.free_count    = '0;
         nxt.unknown_count = '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/free_run_gap_classifier.sv
// top level of the free run gap classifier
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tdata: cell_class, in_bounds, column; tlast: line_end
//  rsp_     out  rsp_tvalid/tready     tdata: run_begin, run_finish; tuser: verdict
//  csr_     in   csr_valid/csr_ready   csr_index, csr_data
//
// one cell per cycle while the result side does not stall; a request is held in
// the input register, and a report that it closes goes on to the result register.
// reset clears the run state, both valid flags and loads the register defaults.
// a stalled result holds the result register; the input register still takes
// a request in the same cycle that the waiting result is taken.
// csr writes are always ready and are meant for idle periods only.
`default_nettype none
`include "free_run_gap_classifier_defines.svh"

module free_run_gap_classifier #(
   parameter int unsigned LINE_LENGTH = fgc_pkg::LINE_LENGTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // cell_class[1:0], in_bounds[2], column[14:3]
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // run_begin[11:0], run_finish[24:12]
   output logic [1:0]  rsp_tuser,   // verdict[1:0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [11:0] csr_data
);

   fgc_pkg::cfg_type       cfg_ff;
   fgc_pkg::run_state_type state_ff;
   fgc_pkg::run_state_type state_in;
   fgc_pkg::cell_type      cell_ff;
   fgc_pkg::result_type    step_res;
   logic                   in_valid_ff;
   logic                   advance;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   fgc_pkg::verdict_type   verdict_ff;
   logic [11:0]            begin_ff;
   logic [12:0]            finish_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_run_length    <= 12'd8;
         cfg_ff.unknown_tolerance <= 8'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            fgc_pkg::CSR_MIN_RUN_LENGTH:    cfg_ff.min_run_length    <= csr_data;
            fgc_pkg::CSR_UNKNOWN_TOLERANCE: cfg_ff.unknown_tolerance <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // the held cell moves on once the result register can take its report
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cell_ff.cell_class <= req_tdata[1:0];
         cell_ff.in_bounds  <= req_tdata[2];
         cell_ff.column     <= req_tdata[14:3];
         cell_ff.line_end   <= req_tlast;
      end
   end

   fgc_step #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_step (
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .cur_cell (cell_ff),
      .nxt      (state_in),
      .res      (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && step_res.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_res.emit) begin
         verdict_ff <= step_res.verdict;
         begin_ff   <= step_res.run_begin;
         finish_ff  <= step_res.run_finish;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, finish_ff, begin_ff};
   assign rsp_tuser  = verdict_ff;

   // unknowns are only counted inside an open run
   `FGC_ASSERT(a_unk_needs_run, clock, reset,
               (state_ff.free_count == '0) |-> (state_ff.unknown_count == '0))
   `FGC_ASSERT_NEVER(a_verdict_code, clock, reset,
                     rsp_tvalid && (rsp_tuser > fgc_pkg::VERDICT_SHORT))
   `FGC_ASSERT(a_oob_drops_run, clock, reset,
               (advance && !cell_ff.in_bounds) |=> (state_ff.free_count == '0))
   `FGC_ASSERT(a_short_only_oob, clock, reset,
               (advance && step_res.emit && (step_res.verdict == fgc_pkg::VERDICT_SHORT))
               |-> !cell_ff.in_bounds)

endmodule

`default_nettype wire

FILE: tb/sv/run_tracker_pkg.sv
// run tracking scoreboard for the free run gap classifier testbench
`timescale 1ns / 100ps

package run_tracker_pkg;

   import fgc_pkg::*;

   typedef struct {
      verdict_type      verdict;
      logic [COL_W-1:0] run_begin;
      logic [FIN_W-1:0] run_finish;
   } run_report_t;

   class run_tracker;
      logic [11:0]       min_len;
      logic [UNK_W-1:0]  tolerance;
      logic [COL_W-1:0]  run_start;
      logic [FREE_W-1:0] free_cnt;
      logic [UNK_W-1:0]  unk_cnt;
      run_report_t       expected_runs[$];
      int                fails;

      function new();
         min_len   = 12'd8;
         tolerance = 8'd2;
         run_start = '0;
         free_cnt  = '0;
         unk_cnt   = '0;
         fails     = 0;
      endfunction

      function void set_register(logic idx, logic [11:0] value);
         if (idx == CSR_MIN_RUN_LENGTH) begin
            min_len = value;
         end else begin
            tolerance = value[UNK_W-1:0];
         end
      endfunction

      function void push_run(verdict_type verdict, int finish);
         run_report_t rep;
         rep.verdict    = verdict;
         rep.run_begin  = run_start;
         rep.run_finish = FIN_W'(finish);
         expected_runs.insert(expected_runs.size(), rep);
      endfunction

      // one request in, at most one closed run out
      function void note_cell(logic [1:0] cls, logic inb, logic [COL_W-1:0] col, logic le);
         bit last;
         int fin;
         last = le || (int'(col) + 1 >= int'(LINE_LENGTH));
         if (!inb) begin
            if (free_cnt != 0 && free_cnt < FREE_W'(min_len)) begin
               push_run(VERDICT_SHORT, int'(col) - 1);
            end
            free_cnt = '0;
            unk_cnt  = '0;
         end else if (cls == CELL_FREE && !last) begin
            if (free_cnt == 0) begin
               run_start = col;
            end
            if (free_cnt != FREE_MAX) begin
               free_cnt = free_cnt + 1'b1;
            end
            unk_cnt = '0;
         end else if (cls == CELL_UNKNOWN && unk_cnt < tolerance && free_cnt != 0 && !last) begin
            unk_cnt = unk_cnt + 1'b1;
         end else if (free_cnt != 0) begin
            // run ends before the trailing unknown cells
            fin = int'(col) - 1 - int'(unk_cnt);
            if (fin - int'(run_start) >= int'(min_len)) begin
               push_run(VERDICT_GAP, fin);
            end else begin
               push_run(VERDICT_NARROW, fin);
            end
            free_cnt = '0;
            unk_cnt  = '0;
         end
      endfunction

      function void check_run(logic [1:0] verdict, logic [COL_W-1:0] first_col,
                              logic [FIN_W-1:0] last_col);
         run_report_t want;
         if (expected_runs.size() == 0) begin
            $error("result with none expected: verdict %0d run %0d..%0d",
                   verdict, first_col, $signed(last_col));
            fails++;
            return;
         end
         want = expected_runs.pop_front();
         if (verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict);
            fails++;
         end
         if (first_col !== want.run_begin) begin
            $error("run_begin: expected %0d, got %0d", want.run_begin, first_col);
            fails++;
         end
         if (last_col !== want.run_finish) begin
            $error("run_finish: expected %0d, got %0d",
                   $signed(want.run_finish), $signed(last_col));
            fails++;
         end
      endfunction

      function int outstanding();
         return expected_runs.size();
      endfunction

      function void close_out();
         if (expected_runs.size() != 0) begin
            $error("%0d expected runs never reported", expected_runs.size());
            fails++;
         end
      endfunction
   endclass

endpackage

FILE: tb/sv/tb_top.sv
// top level testbench for the free run gap classifier
`timescale 1ns / 100ps

module tb_top;

   import fgc_pkg::*;
   import run_tracker_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [1:0] CELL_RESERVED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // cell_class[1:0], in_bounds[2], column[14:3]
   logic        req_tlast;   // line_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // run_begin[11:0], run_finish[24:12]
   logic [1:0]  rsp_tuser;   // verdict[1:0]
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [11:0] csr_data;

   run_tracker board = new();
   bit         burst = 0;
   bit         eager = 0;
   int         idle_cycles = 0;

   free_run_gap_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      return burst ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [1:0] pick_class();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return CELL_FREE;
      if (roll < 75) return CELL_UNKNOWN;
      if (roll < 95) return CELL_OCCUPIED;
      return CELL_RESERVED;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_cell(input logic [1:0] cls, input logic inb,
                            input logic [11:0] col, input logic le);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {1'b0, col, inb, cls};
      req_tlast  <= le;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_cell(cls, inb, col, le);
      @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [11:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [11:0] min_len, input logic [7:0] tol);
      write_register(CSR_MIN_RUN_LENGTH, min_len);
      write_register(CSR_UNKNOWN_TOLERANCE, {4'($urandom), tol});
      csr_valid <= 1'b0;
   endtask

   // all results in, then idle so that a request that closes no run also drains
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one scanned line with runs of similar cells
   task automatic send_line(output int count);
      int len;
      int base;
      int i;
      logic [1:0] cls;
      logic inb;
      logic le;
      len = $urandom_range(2, 40);
      case ($urandom_range(0, 3))
         0: base = 0;
         1: base = 4096 - len;
         default: base = $urandom_range(0, 4095 - len);
      endcase
      burst = ($urandom_range(0, 7) == 0);
      cls = CELL_FREE;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 45) cls = pick_class();
         inb = ($urandom_range(0, 99) >= 4);
         le  = (i == len - 1) && ($urandom_range(0, 9) != 0);
         send_cell(cls, inb, 12'(base + i), le);
      end
      burst = 0;
      count = len;
   endtask

   task automatic send_random(input int total);
      int sent;
      int n;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 9) != 0) begin
            send_line(n);
            sent += n;
         end else begin
            send_cell(2'($urandom), 1'($urandom), 12'($urandom),
                      1'($urandom_range(0, 3) == 0));
            sent++;
         end
      end
   endtask

   initial begin : sink
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) eager = !eager;
         stall = eager ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_run(rsp_tuser, rsp_tdata[11:0], rsp_tdata[24:12]);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = 1'b0;
      csr_data   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases on the register defaults
      send_cell(CELL_OCCUPIED, 1'b1, 12'd5, 1'b0);      // nothing open
      send_cell(CELL_FREE, 1'b1, 12'd0, 1'b1);          // last cell, nothing open
      send_cell(CELL_FREE, 1'b1, 12'd0, 1'b0);
      send_cell(CELL_FREE, 1'b0, 12'd0, 1'b0);          // short run ending at -1
      send_cell(CELL_FREE, 1'b1, 12'd10, 1'b0);
      send_cell(CELL_FREE, 1'b1, 12'd11, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd12, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd13, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd14, 1'b0);      // one unknown too many
      send_cell(CELL_FREE, 1'b1, 12'd100, 1'b0);
      send_cell(CELL_FREE, 1'b1, 12'd200, 1'b0);
      send_cell(CELL_OCCUPIED, 1'b1, 12'd300, 1'b0);    // wide gap
      send_cell(CELL_FREE, 1'b1, 12'd20, 1'b0);
      send_cell(CELL_RESERVED, 1'b1, 12'd25, 1'b0);     // class three closes
      send_cell(CELL_FREE, 1'b1, 12'd4000, 1'b0);
      send_cell(CELL_FREE, 1'b1, 12'd4095, 1'b0);       // last by column
      send_cell(CELL_FREE, 1'b1, 12'd50, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd51, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd60, 1'b1);      // span right at threshold
      send_cell(CELL_FREE, 1'b1, 12'd7, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b0, 12'd4095, 1'b1);
      send_cell(CELL_FREE, 1'b1, 12'd0, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd0, 1'b0);
      send_cell(CELL_UNKNOWN, 1'b1, 12'd0, 1'b0);
      send_cell(CELL_OCCUPIED, 1'b1, 12'd0, 1'b0);      // finish below begin

      settle();
      configure(12'd0, 8'd0);
      send_random(180);

      settle();
      configure(12'd4095, 8'd255);
      send_random(150);
      send_random(30);

      settle();
      configure(12'd1, 8'd1);
      send_random(180);

      settle();
      configure(12'($urandom_range(0, 24)), 8'($urandom_range(0, 5)));
      send_random(180);

      settle();
      configure(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
      send_random(180);

      settle();
      configure(12'd6, 8'd3);
      send_random(180);

      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      board.close_out();
      if (board.fails == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
